// ----- rtl/mtg_pkg.sv -----
// Shared types and constants of the MT19937 generator.
// No dependencies; every other file imports this package.
package mtg_pkg;

    localparam int STATE_WORDS = 624;
    localparam int IDX_W       = 10;
    localparam int WORD_W      = 32;
    localparam int CMD_W       = 2;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [WORD_W-1:0] word_t;

    localparam idx_t LAST_IDX     = idx_t'(STATE_WORDS - 1);
    localparam idx_t FULL_POS     = idx_t'(STATE_WORDS);
    localparam idx_t UNSEEDED_POS = idx_t'(STATE_WORDS + 1);
    localparam idx_t MID_OFFSET   = idx_t'(397);
    localparam idx_t WRAP_IDX     = idx_t'(STATE_WORDS - 397);

    localparam word_t TWIST_XOR  = 32'h9908_b0df;
    localparam word_t TEMPER_B   = 32'hefc6_0000 ^ 32'hefc6_0000 ^ 32'h9d2c_5680;
    localparam word_t TEMPER_C   = 32'hefc6_0000;
    localparam word_t SEED_MULT  = 32'd69069;
    localparam word_t SEED_RESET = 32'd4357;

    typedef enum logic [CMD_W-1:0] {
        CMD_DRAW      = 2'd0,
        CMD_RESEED    = 2'd1,
        CMD_LOAD_WORD = 2'd2,
        CMD_LOAD_POS  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_A,
        ST_SEED_B,
        ST_PRIME,
        ST_TW_RD,
        ST_TW_WR,
        ST_DR_RD,
        ST_DR_OUT
    } state_t;

endpackage

// ----- rtl/mtg_intf.sv -----
// Valid/ready channel interfaces for the generator's request and result sides.
// Depends on mtg_pkg for field widths.
interface mtg_req_if import mtg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [IDX_W-1:0]    word_index;
    logic [WORD_W-1:0]   word_value;

    modport source (output valid, output cmd, output word_index, output word_value,
                    input ready);
    modport sink   (input valid, input cmd, input word_index, input word_value,
                    output ready);
endinterface

interface mtg_rsp_if import mtg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

// ----- rtl/mersenne_twister_generator.sv -----
// MT19937 generator with 69069-based seeding; 624x32 state memory and sequencer.
// Depends on mtg_pkg and the channel interfaces in mtg_intf.sv.
//
// One request at a time. A draw inside the current block of 624 words goes
// through accept, memory read and temper into the output register; the result
// register lets the next request be accepted while the result waits. A draw at
// position 624 first twists the whole state with a read-then-write loop over
// the state memory (two read ports, one write port), through ST_TW_RD and then
// ST_TW_WR for each word. A draw on an unseeded state runs the seeding sweep
// first, and a reseed request runs the sweep alone; each word passes through
// ST_SEED_A and ST_SEED_B since it needs two chained 69069 multiplies. Load
// word and load position requests finish when accepted. The state memory has no
// reset; after reset the state counts as unseeded.
module mersenne_twister_generator
    import mtg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [WORD_W-1:0]  cfg_wdata,
    mtg_req_if.sink            request,
    mtg_rsp_if.source          result
);

    logic [WORD_W-1:0] state_mem [STATE_WORDS];

    state_t  state_reg, state_next;
    idx_t    pos_reg, pos_next;
    idx_t    idx_reg, idx_next;
    word_t   cur_reg, cur_next;
    word_t   s_reg, s_next;
    logic [15:0] hi_reg, hi_next;
    logic    draw_pend_reg, draw_pend_next;
    word_t   seed_reg;
    logic    out_valid_reg, out_valid_next;
    word_t   out_data_reg, out_data_next;
    word_t   rd_a_reg, rd_b_reg;

    logic    mem_we;
    idx_t    mem_waddr;
    word_t   mem_wdata;
    logic    rd_a_en, rd_b_en;
    idx_t    rd_a_addr, rd_b_addr;

    logic    req_fire;
    word_t   twist_y, twist_word;
    idx_t    next_idx, far_idx;

    function automatic word_t temper(input word_t v);
        word_t y;
        y = v;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    assign req_fire      = request.valid && request.ready;
    assign request.ready = (state_reg == ST_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.random_value = out_data_reg;

    assign next_idx = (idx_reg == LAST_IDX) ? '0 : idx_reg + idx_t'(1);
    assign far_idx  = (idx_reg < WRAP_IDX) ? idx_reg + MID_OFFSET : idx_reg - WRAP_IDX;

    // cur_reg is the old word k; rd_a the word after it, rd_b the word 397 on
    assign twist_y    = {cur_reg[WORD_W-1], rd_a_reg[WORD_W-2:0]};
    assign twist_word = rd_b_reg ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_XOR : '0);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        s_next         = s_reg;
        hi_next        = hi_reg;
        draw_pend_next = draw_pend_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = twist_word;
        rd_a_en        = 1'b0;
        rd_a_addr      = next_idx;
        rd_b_en        = 1'b0;
        rd_b_addr      = far_idx;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (cmd_t'(request.cmd))
                        CMD_DRAW:
                        begin
                            if (pos_reg == UNSEEDED_POS)
                            begin
                                s_next         = seed_reg;
                                idx_next       = '0;
                                draw_pend_next = 1'b1;
                                state_next     = ST_SEED_A;
                            end
                            else if (pos_reg >= FULL_POS)
                            begin
                                state_next = ST_PRIME;
                            end
                            else
                            begin
                                state_next = ST_DR_RD;
                            end
                        end
                        CMD_RESEED:
                        begin
                            s_next         = seed_reg;
                            idx_next       = '0;
                            draw_pend_next = 1'b0;
                            state_next     = ST_SEED_A;
                        end
                        CMD_LOAD_WORD:
                        begin
                            mem_we    = (request.word_index < FULL_POS);
                            mem_waddr = request.word_index;
                            mem_wdata = request.word_value;
                        end
                        CMD_LOAD_POS:
                        begin
                            if (request.word_value > WORD_W'(STATE_WORDS + 1))
                                pos_next = FULL_POS;
                            else
                                pos_next = request.word_value[IDX_W-1:0];
                        end
                        default: ;
                    endcase
                end
            end
            ST_SEED_A:
            begin
                hi_next    = s_reg[WORD_W-1:16];
                s_next     = s_reg * SEED_MULT + 32'd1;
                state_next = ST_SEED_B;
            end
            ST_SEED_B:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = {hi_reg, s_reg[WORD_W-1:16]};
                s_next    = s_reg * SEED_MULT + 32'd1;
                if (idx_reg == LAST_IDX)
                begin
                    pos_next   = FULL_POS;
                    state_next = draw_pend_reg ? ST_PRIME : ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + idx_t'(1);
                    state_next = ST_SEED_A;
                end
            end
            ST_PRIME:
            begin
                rd_a_en    = 1'b1;
                rd_a_addr  = '0;
                idx_next   = '0;
                state_next = ST_TW_RD;
            end
            ST_TW_RD:
            begin
                cur_next   = rd_a_reg;
                rd_a_en    = 1'b1;
                rd_b_en    = 1'b1;
                state_next = ST_TW_WR;
            end
            ST_TW_WR:
            begin
                mem_we = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    pos_next   = '0;
                    state_next = ST_DR_RD;
                end
                else
                begin
                    idx_next   = idx_reg + idx_t'(1);
                    state_next = ST_TW_RD;
                end
            end
            ST_DR_RD:
            begin
                rd_a_en    = 1'b1;
                rd_a_addr  = pos_reg;
                state_next = ST_DR_OUT;
            end
            ST_DR_OUT:
            begin
                // hold until the result register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_data_next  = temper(rd_a_reg);
                    out_valid_next = 1'b1;
                    pos_next       = pos_reg + idx_t'(1);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= UNSEEDED_POS;
            draw_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            seed_reg      <= SEED_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            draw_pend_reg <= draw_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                seed_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        cur_reg      <= cur_next;
        s_reg        <= s_next;
        hi_reg       <= hi_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            state_mem[mem_waddr] <= mem_wdata;
        if (rd_a_en)
            rd_a_reg <= state_mem[rd_a_addr];
        if (rd_b_en)
            rd_b_reg <= state_mem[rd_b_addr];
    end

`ifndef NO_ASSERTIONS
    a_result_from_draw: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DR_OUT))
        else $error("result raised outside the draw output step");

    a_twist_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TW_WR && idx_reg == LAST_IDX)
            |=> (pos_reg == '0 && state_reg == ST_DR_RD))
        else $error("twist did not finish with position zero");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (rd_a_en || rd_b_en))
            |-> (mem_waddr != rd_a_addr && mem_waddr != rd_b_addr))
        else $error("state memory read and written at the same entry");

    a_unseeded_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && request.cmd == CMD_DRAW && pos_reg == UNSEEDED_POS)
            |=> (state_reg == ST_SEED_A && draw_pend_reg))
        else $error("draw on unseeded state skipped seeding");
`endif

endmodule

// ----- bench/mtg_output_checker.sv -----
`timescale 1ns / 100ps
// Output checker for mersenne_twister_generator: follows the seed register port and
// both channels, predicts the word of every draw and compares it with the result.
// Depends on mtg_pkg and the channel interfaces in mtg_intf.sv.
module mtg_output_checker
    import mtg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_we,
    input  word_t cfg_wdata,
    mtg_req_if    req_ch,
    mtg_rsp_if    rsp_ch,
    output int    error_count,
    output int    pending_count
);

    localparam int    NUM_WORDS   = STATE_WORDS;
    localparam int    FAR_OFFSET  = 397;
    localparam int    NOT_SEEDED  = NUM_WORDS + 1;
    localparam word_t TWIST_MASK  = 32'h9908_b0df;
    localparam word_t TOP_BIT_MASK  = 32'h8000_0000;
    localparam word_t LOW_BITS_MASK = 32'h7fff_ffff;
    localparam word_t TEMPER_MASK_B = 32'h9d2c_5680;
    localparam word_t TEMPER_MASK_C = 32'hefc6_0000;
    localparam word_t HALF_MASK   = 32'hffff_0000;
    localparam word_t LCG_MULT    = 32'd69069;
    localparam word_t RESET_SEED  = 32'd4357;
    localparam int    REPORT_MAX  = 10;

    word_t mt_words [NUM_WORDS];
    int    mt_pos;
    word_t seed_reg;
    word_t expected_values [$];
    int    errors = 0;

    // Old-style seeding: two LCG steps per word, upper halves only.
    function automatic void seed_words(word_t s);
        word_t w;
        int    i;
        for (i = 0; i < NUM_WORDS; i++)
        begin
            w = s & HALF_MASK;
            s = s * LCG_MULT + 32'd1;
            w = w | ((s & HALF_MASK) >> 16);
            s = s * LCG_MULT + 32'd1;
            mt_words[i] = w;
        end
        mt_pos = NUM_WORDS;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int    k;
        word_t mix;
        word_t y;
        word_t want;
        if (!rst_n)
        begin
            expected_values.delete();
            mt_pos   = NOT_SEEDED;
            seed_reg = RESET_SEED;
            error_count   <= errors;
            pending_count <= 0;
        end
        else
        begin
            if (cfg_we)
                seed_reg = cfg_wdata;

            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_values.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("%0t: result %h with no draw pending", $realtime,
                                 rsp_ch.random_value);
                end
                else
                begin
                    want = expected_values.pop_front();
                    if (rsp_ch.random_value !== want)
                    begin
                        errors++;
                        if (errors <= REPORT_MAX)
                            $display("%0t: random_value mismatch: expected %h, actual %h",
                                     $realtime, want, rsp_ch.random_value);
                    end
                end
            end

            if (req_ch.valid && req_ch.ready)
            begin
                case (cmd_t'(req_ch.cmd))
                    CMD_DRAW:
                    begin
                        if (mt_pos >= NUM_WORDS)
                        begin
                            if (mt_pos == NOT_SEEDED)
                                seed_words(seed_reg);
                            // in-place twist, later words see already updated ones
                            for (k = 0; k < NUM_WORDS; k++)
                            begin
                                mix = (mt_words[k] & TOP_BIT_MASK)
                                    | (mt_words[(k + 1) % NUM_WORDS] & LOW_BITS_MASK);
                                mt_words[k] = mt_words[(k + FAR_OFFSET) % NUM_WORDS]
                                            ^ (mix >> 1) ^ (mix[0] ? TWIST_MASK : '0);
                            end
                            mt_pos = 0;
                        end
                        y = mt_words[mt_pos];
                        mt_pos++;
                        y ^= y >> 11;
                        y ^= (y << 7) & TEMPER_MASK_B;
                        y ^= (y << 15) & TEMPER_MASK_C;
                        y ^= y >> 18;
                        expected_values.push_back(y);
                    end
                    CMD_RESEED:
                        seed_words(seed_reg);
                    CMD_LOAD_WORD:
                    begin
                        if (req_ch.word_index < NUM_WORDS)
                            mt_words[req_ch.word_index] = req_ch.word_value;
                    end
                    CMD_LOAD_POS:
                    begin
                        // anything past the unseeded mark saturates to a full block
                        if (req_ch.word_value > word_t'(NOT_SEEDED))
                            mt_pos = NUM_WORDS;
                        else
                            mt_pos = int'(req_ch.word_value);
                    end
                    default:
                    begin
                    end
                endcase
            end

            error_count   <= errors;
            pending_count <= expected_values.size();
        end
    end

endmodule

// ----- bench/tb_mersenne_twister_generator.sv -----
`timescale 1ns / 100ps
// Testbench top for mersenne_twister_generator: clock, reset, request and result
// traffic, seed register writes, watchdog and verdict.
// Depends on mtg_pkg, mtg_intf.sv, the generator RTL and mtg_output_checker.
module tb_mersenne_twister_generator;
    import mtg_pkg::*;

    localparam int IDLE_LATENCY = 1400;   // covers a reseed sweep still running
    localparam int STALL_LIMIT  = 20000;
    localparam int PHASE_ITEMS  = 230;
    localparam int LONG_HOLD    = 600;

    logic  clk;
    logic  rst_n;
    logic  cfg_we;
    word_t cfg_wdata;

    mtg_req_if req_ch ();
    mtg_rsp_if rsp_ch ();

    int error_count;
    int pending_count;

    int n_items = 0;
    int n_draw = 0;
    int n_reseed = 0;
    int n_load_word = 0;
    int n_load_pos = 0;
    int n_results = 0;
    int n_seed_writes = 0;
    int idle_cycles = 0;
    bit sender_quiet = 1'b0;
    bit receiver_quiet = 1'b0;

    mersenne_twister_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .request   (req_ch),
        .result    (rsp_ch)
    );

    mtg_output_checker output_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .req_ch        (req_ch),
        .rsp_ch        (rsp_ch),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic idx_t pick_index();
        if ($urandom_range(6) == 0)
            return idx_t'($urandom_range(STATE_WORDS, 1023));
        return idx_t'($urandom_range(0, STATE_WORDS - 1));
    endfunction

    task automatic send_req(cmd_t c, idx_t i, word_t v);
        int gap;
        gap = pick_gap(sender_quiet);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= c;
        req_ch.word_index <= i;
        req_ch.word_value <= v;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        n_items++;
        case (c)
            CMD_DRAW:      n_draw++;
            CMD_RESEED:    n_reseed++;
            CMD_LOAD_WORD: n_load_word++;
            default:       n_load_pos++;
        endcase
    endtask

    task automatic draw_burst(int n);
        repeat (n) send_req(CMD_DRAW, idx_t'($urandom), word_t'($urandom));
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    task automatic write_seed(word_t v);
        wait_drained();
        repeat (IDLE_LATENCY) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        n_seed_writes++;
    endtask

    // Only called once the state is fully seeded, so every draw is legal.
    task automatic run_phase(int budget);
        int   stop_at;
        int   kind;
        idx_t last;
        stop_at = n_items + budget;
        send_req(CMD_RESEED, idx_t'($urandom), word_t'($urandom));
        draw_burst($urandom_range(1, 8));
        while (n_items < stop_at)
        begin
            sender_quiet = ($urandom_range(3) == 0);
            kind = $urandom_range(99);
            if (kind < 40)
                draw_burst($urandom_range(1, 24));
            else if (kind < 60)
            begin
                // near the end of the block: twists, and reseeds on 625
                send_req(CMD_LOAD_POS, idx_t'($urandom), word_t'($urandom_range(600, 625)));
                draw_burst($urandom_range(1, 40));
            end
            else if (kind < 72)
            begin
                // partial state restore, then draw from the first restored word if its index was in range
                last = pick_index();
                send_req(CMD_LOAD_WORD, last, word_t'($urandom));
                repeat ($urandom_range(0, 3))
                    send_req(CMD_LOAD_WORD, pick_index(), word_t'($urandom));
                if (last >= STATE_WORDS)
                    last = idx_t'($urandom_range(0, STATE_WORDS - 1));
                send_req(CMD_LOAD_POS, idx_t'($urandom), word_t'(last));
                draw_burst($urandom_range(1, 6));
            end
            else if (kind < 82)
            begin
                if ($urandom_range(1) == 0)
                    send_req(CMD_LOAD_POS, idx_t'($urandom), word_t'($urandom));
                else
                    send_req(CMD_LOAD_POS, idx_t'($urandom), word_t'($urandom_range(0, 1023)));
                draw_burst($urandom_range(1, 5));
            end
            else if (kind < 90)
                send_req(cmd_t'($urandom_range(3)), idx_t'($urandom), word_t'($urandom));
            else if (kind < 95)
            begin
                send_req(CMD_RESEED, idx_t'($urandom), word_t'($urandom));
                draw_burst($urandom_range(1, 10));
            end
            else
                wait_drained();
        end
    endtask

    // Result side: random back-pressure, one long hold-off while requests keep coming.
    initial
    begin
        int hold;
        bit long_done;
        long_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (!long_done && n_results >= 120)
            begin
                hold = LONG_HOLD;
                long_done = 1'b1;
            end
            else
                hold = pick_gap(receiver_quiet);
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            n_results++;
            if ($urandom_range(39) == 0)
                receiver_quiet = ~receiver_quiet;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
            $display("tb_mersenne_twister_generator: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        word_t seed_plan [4];
        int    ph;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.cmd        <= CMD_DRAW;
        req_ch.word_index <= '0;
        req_ch.word_value <= '0;
        seed_plan = '{32'h0000_0000, 32'hffff_ffff, word_t'($urandom), 32'h0000_0001};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unseeded state: only words written here may be read.
        send_req(CMD_LOAD_WORD, idx_t'(0), 32'hffff_ffff);
        send_req(CMD_LOAD_WORD, idx_t'(STATE_WORDS - 1), 32'h0000_0000);
        send_req(CMD_LOAD_WORD, idx_t'(STATE_WORDS), 32'h1234_5678);    // ignored
        send_req(CMD_LOAD_WORD, idx_t'(1023), 32'hdead_beef);           // ignored
        send_req(CMD_LOAD_POS, '0, word_t'(STATE_WORDS - 1));
        draw_burst(1);
        send_req(CMD_LOAD_POS, idx_t'(1023), 32'h0000_0000);
        draw_burst(1);
        // back to unseeded: the draw seeds with the reset seed, then twists
        send_req(CMD_LOAD_POS, '0, word_t'(STATE_WORDS + 1));
        draw_burst(3);
        send_req(CMD_LOAD_POS, '0, 32'hffff_ffff);                     // saturates
        draw_burst(1);
        send_req(CMD_LOAD_POS, '0, word_t'(STATE_WORDS + 2));          // saturates
        draw_burst(1);
        send_req(CMD_LOAD_POS, '0, word_t'(STATE_WORDS));
        draw_burst(1);
        send_req(CMD_RESEED, idx_t'(1023), 32'hffff_ffff);
        draw_burst(1);
        // restored word right before the block end, draws run across the twist
        send_req(CMD_LOAD_WORD, idx_t'(STATE_WORDS - 2), 32'ha5a5_a5a5);
        send_req(CMD_LOAD_POS, '0, word_t'(STATE_WORDS - 2));
        draw_burst(3);

        run_phase(PHASE_ITEMS);
        for (ph = 0; ph < 4; ph++)
        begin
            write_seed(seed_plan[ph]);
            run_phase(PHASE_ITEMS);
        end

        wait_drained();
        repeat (IDLE_LATENCY) @(posedge clk);

        $display("covered %0d requests: %0d draws, %0d reseeds, %0d word loads, %0d position loads",
                 n_items, n_draw, n_reseed, n_load_word, n_load_pos);
        $display("%0d results checked across %0d seed values incl. zero and all ones",
                 n_results, n_seed_writes + 1);
        if (error_count == 0 && pending_count == 0)
            $display("tb_mersenne_twister_generator: done, clean");
        else
        begin
            $display("%0d mismatches, %0d results missing", error_count, pending_count);
            $display("tb_mersenne_twister_generator: done, errors");
        end
        $finish;
    end

endmodule
